@@ rtl/stps_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package stps_pkg;

    // Field widths
    localparam int IDX_W  = 10;
    localparam int VAL_W  = 32;
    localparam int LEN_W  = 11;
    localparam int FRAC_W = 16;

    // Divider: magnitude quotient of (|num| << FRAC_W) / |den|
    localparam int DIV_W  = VAL_W + FRAC_W;
    localparam int DCNT_W = $clog2(DIV_W);
    localparam int SUM_W  = DIV_W + 2;

    localparam int TABLE_DEPTH_DEF = 1024;

    localparam logic [VAL_W-1:0] POS_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic [VAL_W-1:0] POS_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    typedef enum logic [1:0] {
        ACT_WRITE   = 2'd0,
        ACT_UPPER   = 2'd1,
        ACT_CLOSEST = 2'd2,
        ACT_LINEAR  = 2'd3
    } t_action;

endpackage

`default_nettype wire

@@ rtl/stps_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module stps_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

@@ rtl/sorted_table_position_search.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel    Direction  Handshake           Payload
// input      in         i_valid / o_stall   i_action, i_entry_index, i_entry_value,
//                                           i_query_value
// output     out        o_valid / i_stall   o_result_index, o_result_position,
//                                           o_position_saturated
// config     in         i_cfg_wr_en         i_cfg_wr_data (table length)
//
// One transaction is in flight at a time; o_stall is high from acceptance until the
// result is moved into the output register. Each binary search probe has an issue
// state and a compare state on the single registered RAM read port; linear mode then
// runs a bit-serial divider that yields DIV_W (48) quotient bits. A result waiting on
// i_stall holds the output register; the next transaction is still accepted and
// stalls only in S_DONE. Reset is synchronous, active low, and clears the table
// length; the table contents are not cleared.

module sorted_table_position_search
    import stps_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    // config
    input  wire logic                    i_cfg_wr_en,
    input  wire logic [LEN_W-1:0]        i_cfg_wr_data,
    // input channel
    input  wire logic                    i_valid,
    output logic                         o_stall,
    input  wire logic [1:0]              i_action,
    input  wire logic [IDX_W-1:0]        i_entry_index,
    input  wire logic signed [VAL_W-1:0] i_entry_value,
    input  wire logic signed [VAL_W-1:0] i_query_value,
    // output channel
    output logic                         o_valid,
    input  wire logic                    i_stall,
    output logic [IDX_W-1:0]             o_result_index,
    output logic signed [VAL_W-1:0]      o_result_position,
    output logic                         o_position_saturated
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int LW = $clog2(TABLE_DEPTH + 1);
    localparam int CW = (LEN_W > LW) ? LEN_W : LW;
    localparam int SW = (IDX_W > LW) ? IDX_W : LW;
    localparam logic [CW-1:0] DEPTH_C  = CW'(TABLE_DEPTH);
    localparam logic [SW-1:0] SLOT_LIM = SW'(TABLE_DEPTH);

    typedef enum logic [4:0] {
        S_IDLE,
        S_UP_ISSUE,
        S_UP_CMP,
        S_LB_ISSUE,
        S_LB_CMP,
        S_CL_RD_A,
        S_CL_RD_B,
        S_CL_DIFF,
        S_CL_CMP,
        S_LN_CHK,
        S_LN_DEC,
        S_LN_RD0,
        S_LN_RD1,
        S_LN_PREP,
        S_LN_ABS,
        S_LN_DIV,
        S_LN_SUM,
        S_DONE
    } t_state;

    // Registers
    t_state                    r_state, n_state;
    logic [LEN_W-1:0]          r_cfg_len;
    t_action                   r_mode, n_mode;
    logic signed [VAL_W-1:0]   r_key, n_key;
    logic [LW-1:0]             r_lo, n_lo;      // lower bound lo, or upper-search index
    logic [LW-1:0]             r_hi, n_hi;      // lower bound hi, or upper-search count
    logic [LW-1:0]             r_mid, n_mid;    // probe index, or upper-search step
    logic signed [VAL_W-1:0]   r_a0, n_a0;
    logic signed [VAL_W:0]     r_nd, n_nd;
    logic signed [VAL_W:0]     r_dd, n_dd;
    logic [VAL_W-1:0]          r_rem, n_rem;
    logic [DIV_W-1:0]          r_quo, n_quo;
    logic [VAL_W-1:0]          r_den, n_den;
    logic                      r_neg, n_neg;
    logic [DCNT_W-1:0]         r_dcnt, n_dcnt;
    logic [LW-1:0]             r_ridx, n_ridx;
    logic [VAL_W-1:0]          r_rpos, n_rpos;
    logic                      r_rsat, n_rsat;
    logic                      r_valid, n_valid;
    logic [IDX_W-1:0]          r_out_idx, n_out_idx;
    logic [VAL_W-1:0]          r_out_pos, n_out_pos;
    logic                      r_out_sat, n_out_sat;

    // Combinational
    logic                      w_in_acc;
    t_action                   w_act;
    logic [CW-1:0]             w_len_ext;
    logic [LW-1:0]             w_len;
    logic [LW-1:0]             w_len_m1;
    logic [SW-1:0]             w_slot_ext;
    logic                      w_ram_we;
    logic [LW-1:0]             w_raddr;
    logic [VAL_W-1:0]          w_ram_rdata;
    logic signed [VAL_W-1:0]   w_rd;
    logic [LW:0]               w_lb_sum;
    logic [LW-1:0]             w_mid;
    logic [LW-1:0]             w_step;
    logic [LW-1:0]             w_up_addr;
    logic [LW-1:0]             w_lo_p1;
    logic [LW-1:0]             w_lo_m1;
    logic [LW-1:0]             w_cl_idx;
    logic [VAL_W:0]            w_nd_mag;
    logic [VAL_W:0]            w_dd_mag;
    logic [VAL_W:0]            w_trial;
    logic                      w_qbit;
    logic signed [SUM_W-1:0]   w_base;
    logic signed [SUM_W-1:0]   w_quo_ext;
    logic signed [SUM_W-1:0]   w_sum;
    logic [SUM_W-VAL_W:0]      w_sum_top;
    logic                      w_ovf;
    logic [SW-1:0]             w_ridx_ext;

    assign w_act      = t_action'(i_action);
    assign o_stall    = (r_state != S_IDLE);
    assign w_in_acc   = i_valid && !o_stall;

    // Effective length: min(table length register, depth)
    assign w_len_ext  = CW'(r_cfg_len);
    assign w_len      = (w_len_ext < DEPTH_C) ? w_len_ext[LW-1:0] : DEPTH_C[LW-1:0];
    assign w_len_m1   = w_len - LW'(1);

    // Drop writes to slots beyond the table
    assign w_slot_ext = SW'(i_entry_index);
    assign w_ram_we   = w_in_acc && (w_act == ACT_WRITE) && (w_slot_ext < SLOT_LIM);

    assign w_rd       = $signed(w_ram_rdata);
    assign w_lb_sum   = {1'b0, r_lo} + {1'b0, r_hi};
    assign w_mid      = w_lb_sum[LW:1];
    assign w_step     = r_hi >> 1;
    assign w_up_addr  = r_lo + w_step;
    assign w_lo_p1    = r_lo + LW'(1);
    assign w_lo_m1    = r_lo - LW'(1);
    assign w_cl_idx   = (r_lo == w_len) ? w_len_m1 : r_lo;

    assign w_nd_mag   = r_nd[VAL_W] ? -r_nd : r_nd;
    assign w_dd_mag   = r_dd[VAL_W] ? -r_dd : r_dd;

    // Restoring divider step, one quotient bit per cycle
    assign w_trial    = {r_rem, r_quo[DIV_W-1]} - {1'b0, r_den};
    assign w_qbit     = !w_trial[VAL_W];

    // Position = idx * 2^16 +/- quotient, then saturate to 32 bits
    assign w_base     = $signed(SUM_W'({r_lo, {FRAC_W{1'b0}}}));
    assign w_quo_ext  = $signed(SUM_W'(r_quo));
    assign w_sum      = r_neg ? (w_base - w_quo_ext) : (w_base + w_quo_ext);
    assign w_sum_top  = w_sum[SUM_W-1:VAL_W-1];
    assign w_ovf      = !((w_sum_top == '0) || (w_sum_top == '1));

    assign w_ridx_ext = SW'(r_ridx);

    // Read address per probe state
    always_comb begin
        unique case (r_state)
            S_LB_ISSUE: w_raddr = w_mid;
            S_UP_ISSUE: w_raddr = w_up_addr;
            S_CL_RD_B:  w_raddr = w_lo_m1;
            S_LN_RD1:   w_raddr = w_lo_p1;
            default:    w_raddr = r_lo;
        endcase
    end

    stps_ram #(
        .WIDTH (VAL_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_slot_ext[AW-1:0]),
        .i_wdata (i_entry_value),
        .i_raddr (w_raddr[AW-1:0]),
        .o_rdata (w_ram_rdata)
    );

    // Sequencer
    always_comb begin
        n_state   = r_state;
        n_mode    = r_mode;
        n_key     = r_key;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_mid     = r_mid;
        n_a0      = r_a0;
        n_nd      = r_nd;
        n_dd      = r_dd;
        n_rem     = r_rem;
        n_quo     = r_quo;
        n_den     = r_den;
        n_neg     = r_neg;
        n_dcnt    = r_dcnt;
        n_ridx    = r_ridx;
        n_rpos    = r_rpos;
        n_rsat    = r_rsat;
        n_out_idx = r_out_idx;
        n_out_pos = r_out_pos;
        n_out_sat = r_out_sat;
        n_valid   = r_valid;

        // Drop the output transaction once taken
        if (r_valid && !i_stall) begin
            n_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_mode = w_act;
                    n_key  = i_query_value;
                    n_ridx = '0;
                    n_rpos = '0;
                    n_rsat = 1'b0;
                    n_lo   = '0;
                    if (w_act == ACT_WRITE || w_len == '0) begin
                        n_state = S_DONE;
                    end else if (w_act == ACT_UPPER) begin
                        n_hi    = w_len_m1;
                        n_state = S_UP_ISSUE;
                    end else begin
                        n_hi    = w_len;
                        n_state = S_LB_ISSUE;
                    end
                end
            end

            // Upper search: idx in r_lo, count in r_hi, step in r_mid
            S_UP_ISSUE: begin
                if (r_hi == '0) begin
                    n_ridx  = r_lo;
                    n_state = S_DONE;
                end else begin
                    n_mid   = w_step;
                    n_state = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                if (r_key >= w_rd) begin
                    n_lo = r_lo + r_mid + LW'(1);
                    n_hi = r_hi - r_mid - LW'(1);
                end else begin
                    n_hi = r_mid;
                end
                n_state = S_UP_ISSUE;
            end

            // Lower bound over [r_lo, r_hi)
            S_LB_ISSUE: begin
                if (r_lo < r_hi) begin
                    n_mid   = w_mid;
                    n_state = S_LB_CMP;
                end else if (r_mode == ACT_CLOSEST) begin
                    if (w_cl_idx == '0) begin
                        n_ridx  = '0;
                        n_state = S_DONE;
                    end else begin
                        n_lo    = w_cl_idx;
                        n_state = S_CL_RD_A;
                    end
                end else if (r_mode == ACT_LINEAR) begin
                    if (r_lo == '0) begin
                        n_state = S_LN_RD0;
                    end else if (r_lo == w_len) begin
                        n_lo    = w_len_m1;
                        n_state = S_LN_RD0;
                    end else begin
                        n_state = S_LN_CHK;
                    end
                end else begin
                    n_state = S_DONE;
                end
            end
            S_LB_CMP: begin
                if (w_rd < r_key) begin
                    n_lo = r_mid + LW'(1);
                end else begin
                    n_hi = r_mid;
                end
                n_state = S_LB_ISSUE;
            end

            // Closest: compare distances to entries idx and idx-1
            S_CL_RD_A: begin
                n_state = S_CL_RD_B;
            end
            S_CL_RD_B: begin
                n_a0    = w_rd;
                n_state = S_CL_DIFF;
            end
            S_CL_DIFF: begin
                n_nd    = {r_a0[VAL_W-1], r_a0} - {r_key[VAL_W-1], r_key};
                n_dd    = {w_rd[VAL_W-1], w_rd} - {r_key[VAL_W-1], r_key};
                n_state = S_CL_CMP;
            end
            S_CL_CMP: begin
                n_ridx  = (w_nd_mag < w_dd_mag) ? r_lo : w_lo_m1;
                n_state = S_DONE;
            end

            // Linear: step back to the floor entry, then interpolate
            S_LN_CHK: begin
                n_state = S_LN_DEC;
            end
            S_LN_DEC: begin
                if (w_rd > r_key) begin
                    n_lo = w_lo_m1;
                end
                n_state = S_LN_RD0;
            end
            S_LN_RD0: begin
                if (w_lo_p1 >= w_len) begin
                    n_quo   = '0;
                    n_neg   = 1'b0;
                    n_state = S_LN_SUM;
                end else begin
                    n_state = S_LN_RD1;
                end
            end
            S_LN_RD1: begin
                n_a0    = w_rd;
                n_state = S_LN_PREP;
            end
            S_LN_PREP: begin
                n_nd    = {r_key[VAL_W-1], r_key} - {r_a0[VAL_W-1], r_a0};
                n_dd    = {w_rd[VAL_W-1], w_rd} - {r_a0[VAL_W-1], r_a0};
                n_state = S_LN_ABS;
            end
            S_LN_ABS: begin
                if (r_nd == '0 || r_dd == '0) begin
                    n_quo   = '0;
                    n_neg   = 1'b0;
                    n_state = S_LN_SUM;
                end else begin
                    n_quo   = {w_nd_mag[VAL_W-1:0], {FRAC_W{1'b0}}};
                    n_den   = w_dd_mag[VAL_W-1:0];
                    n_rem   = '0;
                    n_neg   = r_nd[VAL_W] ^ r_dd[VAL_W];
                    n_dcnt  = DCNT_W'(DIV_W - 1);
                    n_state = S_LN_DIV;
                end
            end
            S_LN_DIV: begin
                n_rem = w_qbit ? w_trial[VAL_W-1:0] : {r_rem[VAL_W-2:0], r_quo[DIV_W-1]};
                n_quo = {r_quo[DIV_W-2:0], w_qbit};
                if (r_dcnt == '0) begin
                    n_state = S_LN_SUM;
                end else begin
                    n_dcnt = r_dcnt - DCNT_W'(1);
                end
            end
            S_LN_SUM: begin
                n_ridx = r_lo;
                n_rsat = w_ovf;
                if (w_ovf) begin
                    n_rpos = w_sum[SUM_W-1] ? POS_MIN : POS_MAX;
                end else begin
                    n_rpos = w_sum[VAL_W-1:0];
                end
                n_state = S_DONE;
            end

            // Hold until the output register is free
            S_DONE: begin
                if (!r_valid || !i_stall) begin
                    n_out_idx = w_ridx_ext[IDX_W-1:0];
                    n_out_pos = r_rpos;
                    n_out_sat = r_rsat;
                    n_valid   = 1'b1;
                    n_state   = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_valid   <= 1'b0;
            r_cfg_len <= '0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            if (i_cfg_wr_en) begin
                r_cfg_len <= i_cfg_wr_data;
            end
        end
        r_mode    <= n_mode;
        r_key     <= n_key;
        r_lo      <= n_lo;
        r_hi      <= n_hi;
        r_mid     <= n_mid;
        r_a0      <= n_a0;
        r_nd      <= n_nd;
        r_dd      <= n_dd;
        r_rem     <= n_rem;
        r_quo     <= n_quo;
        r_den     <= n_den;
        r_neg     <= n_neg;
        r_dcnt    <= n_dcnt;
        r_ridx    <= n_ridx;
        r_rpos    <= n_rpos;
        r_rsat    <= n_rsat;
        r_out_idx <= n_out_idx;
        r_out_pos <= n_out_pos;
        r_out_sat <= n_out_sat;
    end

    assign o_valid              = r_valid;
    assign o_result_index       = r_out_idx;
    assign o_result_position    = $signed(r_out_pos);
    assign o_position_saturated = r_out_sat;

endmodule

`default_nettype wire
